[rtl/tli_pkg.sv]
// shared constants and types for the table interpolation block
package tli_pkg;

    localparam int TableDepth = 256;
    localparam int IdxW       = $clog2(TableDepth);
    localparam int CntW       = IdxW + 1;

    localparam logic ActLoad  = 1'b0;
    localparam logic ActQuery = 1'b1;

    localparam logic [1:0] StatInside = 2'd0;
    localparam logic [1:0] StatBelow  = 2'd1;
    localparam logic [1:0] StatAbove  = 2'd2;

    // divider request: unsigned dividend over unsigned divisor
    typedef struct packed {
        logic        go;
        logic [63:0] num;
        logic [32:0] den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [63:0] quo;
        logic        rem_nz;
    } t_div_rsp;

endpackage

[rtl/tli_div.sv]
// radix-2 restoring divider, one quotient bit per cycle
module tli_div (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tli_pkg::t_div_req i_req,
    output tli_pkg::t_div_rsp o_rsp
);

    logic [63:0] r_quo, n_quo;
    logic [33:0] r_rem, n_rem;
    logic [32:0] r_den, n_den;
    logic [6:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [33:0] shifted;
    logic [34:0] diff;

    always_comb begin
        shifted = {r_rem[32:0], r_quo[63]};
        diff    = {1'b0, shifted} - {2'b00, r_den};
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_den   = r_den;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        if (i_req.go) begin
            n_quo  = i_req.num;
            n_rem  = '0;
            n_den  = i_req.den;
            n_cnt  = 7'd64;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!diff[34]) begin
                n_rem = diff[33:0];
                n_quo = {r_quo[62:0], 1'b1};
            end else begin
                n_rem = shifted;
                n_quo = {r_quo[62:0], 1'b0};
            end
            n_cnt = r_cnt - 7'd1;
            if (r_cnt == 7'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.quo    = r_quo;
    assign o_rsp.rem_nz = (r_rem != '0);

endmodule

[rtl/table_linear_interpolation_top.sv]
// top level: table store, search sequencer and result formatting
//
// channel   dir  handshake                   payload
// request   in   i_start & !o_busy           i_action, i_entry_*, i_query_point
// config    in   i_cfg_we                    i_cfg_entries_in_use
// result    out  o_result_valid (one cycle)  o_interpolated_value, o_range_status
//
// a load is written at its accept edge and the block stays ready. a query runs a binary
// search (up to 9 steps at depth 256), then a memory wait and a classify state; a clamped
// result goes straight to output. an exact hit walks the equal entries, summing their data,
// then averages them in the divider; an interpolation fetches the lower neighbour, forms
// the product in two multiply passes and divides it by the span. both share one radix-2
// divider, and the table memories have a single read port.
// synchronous active-low reset; tables are not cleared. results cannot be stalled.
module table_linear_interpolation_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic               i_cfg_we,
    input  logic [8:0]         i_cfg_entries_in_use,
    input  logic               i_action,
    input  logic [7:0]         i_entry_index,
    input  logic signed [31:0] i_entry_abscissa,
    input  logic signed [31:0] i_entry_data,
    input  logic signed [31:0] i_query_point,
    output logic               o_result_valid,
    output logic signed [31:0] o_interpolated_value,
    output logic [1:0]         o_range_status
);

    localparam int IdxW = tli_pkg::IdxW;
    localparam int CntW = tli_pkg::CntW;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_SRCH  = 12'b000000000010,
        S_SRCHW = 12'b000000000100,
        S_CLASS = 12'b000000001000,
        S_CLSW  = 12'b000000010000,
        S_AVG   = 12'b000000100000,
        S_AVGW  = 12'b000001000000,
        S_NBR   = 12'b000010000000,
        S_PREP  = 12'b000100000000,
        S_MUL   = 12'b001000000000,
        S_DIV   = 12'b010000000000,
        S_OUT   = 12'b100000000000
    } t_state;

    t_state r_state, n_state;

    logic signed [31:0] abs_mem [tli_pkg::TableDepth];
    logic signed [31:0] dat_mem [tli_pkg::TableDepth];
    logic signed [31:0] r_rd_abs, r_rd_dat;
    logic [IdxW-1:0]    rd_addr;

    logic [CntW-1:0] r_cfg_n;
    logic [CntW-1:0] n_act;
    logic [CntW-1:0] r_n, n_n;
    logic [CntW-1:0] r_lo, n_lo, r_hi, n_hi, r_i, n_i;
    logic signed [31:0] r_x, n_x;
    logic signed [31:0] r_x1, n_x1, r_v1, n_v1;
    logic signed [39:0] r_sum, n_sum;
    logic [CntW-1:0]    r_cnt, n_cnt;
    logic               r_avg, n_avg;
    logic [32:0] r_span, n_span, r_dx, n_dx;
    logic [32:0] r_mag, n_mag;
    logic        r_neg, n_neg;
    logic [63:0] r_prod, n_prod;
    logic        r_mphase, n_mphase;
    logic signed [31:0] r_val, n_val;
    logic [1:0]  r_stat, n_stat;
    logic        r_ovalid, n_ovalid;

    logic [CntW-1:0] mid;
    logic signed [32:0] dv;
    logic [49:0] pp;
    tli_pkg::t_div_req div_req;
    tli_pkg::t_div_rsp div_rsp;
    logic signed [65:0] fl, base;
    logic [63:0] avg_mag;

    tli_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(div_req), .o_rsp(div_rsp));

    always_comb begin
        if (i_cfg_entries_in_use == '0)
            n_act = CntW'(1);
        else if (i_cfg_entries_in_use > CntW'(tli_pkg::TableDepth))
            n_act = CntW'(tli_pkg::TableDepth);
        else
            n_act = i_cfg_entries_in_use;
    end

    assign mid = r_lo + ((r_hi - r_lo) >> 1);

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start && i_action == tli_pkg::ActLoad) begin
            abs_mem[i_entry_index] <= i_entry_abscissa;
            dat_mem[i_entry_index] <= i_entry_data;
        end
        r_rd_abs <= abs_mem[rd_addr];
        r_rd_dat <= dat_mem[rd_addr];
    end

    always_comb begin
        rd_addr = r_i[IdxW-1:0];
        if (r_state == S_SRCH) rd_addr = mid[IdxW-1:0];
    end

    // r_v1 holds the upper neighbour, memory gives the lower
    assign dv = {r_v1[31], r_v1} - {r_rd_dat[31], r_rd_dat};
    // 33x17 partial product, two passes over dx halves
    assign pp = r_mag * (r_mphase ? {1'b0, r_dx[32:17]} : r_dx[16:0]);

    always_comb begin
        avg_mag = {24'd0, (r_sum[39] ? -r_sum : r_sum)};
        fl   = r_neg ? -$signed({2'b00, div_rsp.quo}) - 66'(div_rsp.rem_nz)
                     : $signed({2'b00, div_rsp.quo});
        base = 66'(r_v1) + fl;
        if (r_avg) begin
            base = r_neg ? -$signed({2'b00, div_rsp.quo}) : $signed({2'b00, div_rsp.quo});
        end else if (div_rsp.rem_nz && base < 0) begin
            base = base + 66'sd1;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_n = r_n; n_lo = r_lo; n_hi = r_hi; n_i = r_i; n_x = r_x;
        n_x1 = r_x1; n_v1 = r_v1; n_sum = r_sum; n_cnt = r_cnt; n_avg = r_avg;
        n_span = r_span; n_dx = r_dx; n_mag = r_mag; n_neg = r_neg;
        n_prod = r_prod; n_mphase = r_mphase;
        n_val = r_val; n_stat = r_stat; n_ovalid = 1'b0;
        div_req.go = 1'b0;
        div_req.num = avg_mag;
        div_req.den = 33'(r_cnt);
        unique case (r_state)
            S_IDLE: begin
                if (i_start && i_action == tli_pkg::ActQuery) begin
                    n_n = r_cfg_n; n_lo = '0; n_hi = r_cfg_n; n_x = i_query_point;
                    n_state = S_SRCH;
                end
            end
            S_SRCH: begin
                if (r_lo < r_hi) n_state = S_SRCHW;
                else begin
                    n_i = (r_lo >= r_n) ? r_n - CntW'(1) : r_lo;
                    n_state = S_CLSW;
                end
            end
            S_SRCHW: begin
                if (r_rd_abs < r_x) n_lo = mid + CntW'(1);
                else n_hi = mid;
                n_state = S_SRCH;
            end
            S_CLSW: n_state = S_CLASS;
            S_CLASS: begin
                if (r_lo >= r_n) begin
                    n_val = r_rd_dat; n_stat = tli_pkg::StatAbove; n_state = S_OUT;
                end else if (r_rd_abs == r_x) begin
                    n_sum = '0; n_cnt = '0; n_stat = tli_pkg::StatInside;
                    n_state = S_AVG;
                end else if (r_lo == '0) begin
                    n_val = r_rd_dat; n_stat = tli_pkg::StatBelow; n_state = S_OUT;
                end else begin
                    n_x1 = r_rd_abs; n_v1 = r_rd_dat; n_stat = tli_pkg::StatInside;
                    n_i = r_lo - CntW'(1);
                    n_state = S_NBR;
                end
            end
            S_AVG: begin
                // memory holds entry r_i here
                if (r_i < r_n && r_rd_abs == r_x) begin
                    n_sum = r_sum + 40'(r_rd_dat);
                    n_cnt = r_cnt + CntW'(1);
                    n_i = r_i + CntW'(1);
                    n_state = S_AVGW;
                end else begin
                    n_avg = 1'b1; n_neg = r_sum[39];
                    div_req.go = 1'b1;
                    n_state = S_DIV;
                end
            end
            S_AVGW: n_state = S_AVG;
            S_NBR: n_state = S_PREP;
            S_PREP: begin
                // r_x1/r_v1 hold the upper neighbour, memory gives the lower
                n_span = 33'({r_x1[31], r_x1} - {r_rd_abs[31], r_rd_abs});
                n_dx   = 33'({r_x[31], r_x} - {r_rd_abs[31], r_rd_abs});
                n_neg  = dv[32];
                n_mag  = dv[32] ? 33'(-dv) : 33'(dv);
                n_v1   = r_rd_dat;
                n_mphase = 1'b0;
                n_prod = '0;
                n_state = S_MUL;
            end
            S_MUL: begin
                if (!r_mphase) begin
                    n_prod = 64'(pp);
                    n_mphase = 1'b1;
                end else begin
                    n_prod = r_prod + (64'(pp) << 17);
                    n_avg = 1'b0; n_mphase = 1'b0;
                    n_state = S_DIV;
                    div_req.go = 1'b1;
                    div_req.num = r_prod + (64'(pp) << 17);
                    div_req.den = r_span;
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    if (base > 66'sd2147483647) n_val = 32'sh7fffffff;
                    else if (base < -66'sd2147483648) n_val = 32'sh80000000;
                    else n_val = base[31:0];
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                n_ovalid = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cfg_n  <= CntW'(tli_pkg::TableDepth);
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) r_cfg_n <= n_act;
        end
        r_n <= n_n; r_lo <= n_lo; r_hi <= n_hi; r_i <= n_i; r_x <= n_x;
        r_x1 <= n_x1; r_v1 <= n_v1; r_sum <= n_sum; r_cnt <= n_cnt; r_avg <= n_avg;
        r_span <= n_span; r_dx <= n_dx; r_mag <= n_mag; r_neg <= n_neg;
        r_prod <= n_prod;
        r_mphase <= n_mphase;
        r_val <= n_val; r_stat <= n_stat;
    end

    assign o_busy               = (r_state != S_IDLE);
    assign o_result_valid       = r_ovalid;
    assign o_interpolated_value = r_val;
    assign o_range_status       = r_stat;

endmodule
